FILE: hdl/vector3_arithmetic_unit_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vector ALU core
// Clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// condition holds at every edge
`define V3AU_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent at the next edge
`define V3AU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/v3au_pkg.sv
// ----------------------------------------------------------------------------
// v3au_pkg
// Widths, operation and status codes, pipeline record and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package v3au_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
  localparam int SQ_BITS   = 2 * WORD_BITS;
  localparam int PROD_BITS = 2 * WORD_BITS + 2;
  localparam int IN_BITS   = ((4 + 7 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = ((4 * WORD_BITS + 2 + 7) / 8) * 8;

  localparam logic [3:0] F_ADD   = 4'd0;
  localparam logic [3:0] F_ADDS  = 4'd1;
  localparam logic [3:0] F_ADDSC = 4'd2;
  localparam logic [3:0] F_SUB   = 4'd3;
  localparam logic [3:0] F_SCALE = 4'd4;
  localparam logic [3:0] F_DOT   = 4'd5;
  localparam logic [3:0] F_PROD  = 4'd6;
  localparam logic [3:0] F_CROSS = 4'd7;
  localparam logic [3:0] F_MAG   = 4'd8;
  localparam logic [3:0] F_NORM  = 4'd9;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic signed [PROD_BITS-1:0] WORD_MAX =
    $signed({{(PROD_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
  localparam logic signed [PROD_BITS-1:0] WORD_MIN =
    $signed({{(PROD_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}});
  localparam logic signed [PROD_BITS-1:0] FRAC_ONES =
    $signed({{(PROD_BITS-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}});

  typedef struct packed {
    logic [3:0]                     func;
    logic [2:0][WORD_BITS-1:0]      a_raw;
    logic [2:0][WORD_BITS-1:0]      a_abs;
    logic [2:0]                     a_neg;
    logic [3:0][WORD_BITS-1:0]      res;
    logic                           sat;
    logic [SQ_BITS-1:0]             rem_sq;
    logic [WORD_BITS-1:0]           root;
    logic [2:0][WORD_BITS-1:0]      drem;
    logic [2:0][QUO_BITS-1:0]       quo;
  } pipe_t;

  function automatic logic signed [PROD_BITS-1:0] trunc_frac(
    input logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0] bias;
    bias = p[PROD_BITS-1] ? FRAC_ONES : '0;
    return (p + bias) >>> FRAC_BITS;
  endfunction

  // {saturated, word}
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [PROD_BITS-1:0] v);
    logic [WORD_BITS:0] r;
    if (v > WORD_MAX) begin
      r = {1'b1, WORD_MAX[WORD_BITS-1:0]};
    end else if (v < WORD_MIN) begin
      r = {1'b1, WORD_MIN[WORD_BITS-1:0]};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/v3au_front.sv
// ----------------------------------------------------------------------------
// v3au_front
// Product stage and add/truncate/saturate stage; seeds the root and divide chain.
// ----------------------------------------------------------------------------
`default_nettype none

module v3au_front import v3au_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [3:0]                    func,
  input  wire logic [2:0][WORD_BITS-1:0]     a_vec,
  input  wire logic [2:0][WORD_BITS-1:0]     b_vec,
  input  wire logic [WORD_BITS-1:0]          s_val,
  output logic                               out_valid,
  output pipe_t                              out_pipe
);

  logic                                s1_valid;
  logic [3:0]                          s1_func;
  logic [2:0][WORD_BITS-1:0]           s1_a;
  logic [2:0][WORD_BITS-1:0]           s1_b;
  logic [WORD_BITS-1:0]                s1_s;
  logic signed [SQ_BITS-1:0]           s1_pm  [3];
  logic signed [SQ_BITS-1:0]           s1_pbs [3];
  logic signed [SQ_BITS-1:0]           s1_pc1 [3];
  logic signed [SQ_BITS-1:0]           s1_pc2 [3];
  logic signed [SQ_BITS-1:0]           pm     [3];
  logic signed [SQ_BITS-1:0]           pbs    [3];
  logic signed [SQ_BITS-1:0]           pc1    [3];
  logic signed [SQ_BITS-1:0]           pc2    [3];
  pipe_t                               nxt;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic [WORD_BITS-1:0] opnd;

    always_comb begin
      if (func == F_SCALE) begin
        opnd = s_val;
      end else if (func == F_MAG || func == F_NORM) begin
        opnd = a_vec[i];
      end else begin
        opnd = b_vec[i];
      end
    end

    assign pm[i]  = $signed(a_vec[i]) * $signed(opnd);
    assign pbs[i] = $signed(b_vec[i]) * $signed(s_val);
    assign pc1[i] = $signed(a_vec[J]) * $signed(b_vec[K]);
    assign pc2[i] = $signed(a_vec[K]) * $signed(b_vec[J]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func <= func;
      s1_a    <= a_vec;
      s1_b    <= b_vec;
      s1_s    <= s_val;
      for (int i = 0; i < 3; i++) begin
        s1_pm[i]  <= pm[i];
        s1_pbs[i] <= pbs[i];
        s1_pc1[i] <= pc1[i];
        s1_pc2[i] <= pc2[i];
      end
    end
  end

  always_comb begin
    logic signed [PROD_BITS-1:0] av;
    logic signed [PROD_BITS-1:0] bv;
    logic signed [PROD_BITS-1:0] sv;
    logic [WORD_BITS:0]          r;
    logic                        sat_any;
    nxt     = '0;
    sat_any = 1'b0;
    sv      = PROD_BITS'($signed(s1_s));
    for (int i = 0; i < 3; i++) begin
      av = PROD_BITS'($signed(s1_a[i]));
      bv = PROD_BITS'($signed(s1_b[i]));
      case (s1_func)
        F_ADD:   r = sat_word(av + bv);
        F_ADDS:  r = sat_word(av + sv);
        F_ADDSC: r = sat_word(av + trunc_frac(PROD_BITS'(s1_pbs[i])));
        F_SUB:   r = sat_word(av - bv);
        F_SCALE: r = sat_word(trunc_frac(PROD_BITS'(s1_pm[i])));
        F_PROD:  r = sat_word(trunc_frac(PROD_BITS'(s1_pm[i])));
        F_CROSS: r = sat_word(trunc_frac(PROD_BITS'(s1_pc1[i]) - PROD_BITS'(s1_pc2[i])));
        default: r = '0;
      endcase
      nxt.res[i]   = r[WORD_BITS-1:0];
      sat_any      = sat_any | r[WORD_BITS];
      nxt.a_raw[i] = s1_a[i];
      nxt.a_neg[i] = s1_a[i][WORD_BITS-1];
      nxt.a_abs[i] = s1_a[i][WORD_BITS-1] ? WORD_BITS'(-s1_a[i]) : s1_a[i];
    end
    if (s1_func == F_DOT) begin
      r = sat_word(trunc_frac(PROD_BITS'(s1_pm[0]) + PROD_BITS'(s1_pm[1])
                              + PROD_BITS'(s1_pm[2])));
      nxt.res[3] = r[WORD_BITS-1:0];
      sat_any    = sat_any | r[WORD_BITS];
    end
    nxt.func   = s1_func;
    nxt.sat    = sat_any;
    nxt.rem_sq = $unsigned(s1_pm[0]) + $unsigned(s1_pm[1]) + $unsigned(s1_pm[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pipe <= nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/v3au_sqrt_cell.sv
// ----------------------------------------------------------------------------
// v3au_sqrt_cell
// One root bit of the integer square root of the sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module v3au_sqrt_cell import v3au_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire pipe_t in_pipe,
  output logic       out_valid,
  output pipe_t      out_pipe
);

  pipe_t nxt;

  always_comb begin
    logic [SQ_BITS:0] trial;
    logic [SQ_BITS:0] rem_x;
    trial = ((SQ_BITS+1)'(in_pipe.root) << (BIT + 1)) + ((SQ_BITS+1)'(1) << (2 * BIT));
    rem_x = {1'b0, in_pipe.rem_sq};
    nxt   = in_pipe;
    if (rem_x >= trial) begin
      nxt.rem_sq    = SQ_BITS'(rem_x - trial);
      nxt.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pipe <= nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/v3au_div_cell.sv
// ----------------------------------------------------------------------------
// v3au_div_cell
// One quotient bit of the three normalize divisions by the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module v3au_div_cell import v3au_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire pipe_t in_pipe,
  output logic       out_valid,
  output pipe_t      out_pipe
);

  localparam bit HAS_BIT = (BIT >= FRAC_BITS);
  localparam int NIDX    = HAS_BIT ? BIT - FRAC_BITS : 0;

  pipe_t nxt;

  always_comb begin
    logic             nbit;
    logic [WORD_BITS:0] sh;
    nxt = in_pipe;
    for (int i = 0; i < 3; i++) begin
      nbit = HAS_BIT ? in_pipe.a_abs[i][NIDX] : 1'b0;
      sh   = {in_pipe.drem[i], nbit};
      if (sh >= {1'b0, in_pipe.root}) begin
        nxt.drem[i]     = WORD_BITS'(sh - {1'b0, in_pipe.root});
        nxt.quo[i][BIT] = 1'b1;
      end else begin
        nxt.drem[i] = sh[WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pipe <= nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/vector3_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_core
// Three-component Q16.16 vector ALU: add, sub, scale, dot, cross, product, magnitude,
// normalize, with saturation and zero-length status.
//
// One input stream (s_*) carries an operation and two vectors plus a scalar;
// one output stream (m_*) returns a vector, a scalar and a status.
// Every transfer in gives exactly one transfer out, in order.
// Every operation passes through the same registers from the input transfer
// to m_tvalid: two product/arithmetic stages, 32 square-root cells (one root
// bit each), 48 divide cells (one quotient bit each, three lanes) and the
// output register. Throughput is one item per cycle unless the output stalls.
// The whole cell row advances together; when m_tvalid is high and m_tready
// low the row holds and s_tready drops, otherwise s_tready stays high even
// while a result waits in the output register and is taken.
// Reset clears all valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector3_arithmetic_unit_core_assert.svh"

module vector3_arithmetic_unit_core import v3au_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // func[3:0], ax, ay, az, bx, by, bz, scale_value (32 each), zero pad
  input  wire logic [IN_BITS-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // rx, ry, rz, scalar_out (32 each), status[1:0], zero pad
  output logic [OUT_BITS-1:0]       m_tdata
);

  localparam int NCELL = WORD_BITS + QUO_BITS;

  localparam logic [QUO_BITS-1:0] Q_POS_LIM = QUO_BITS'({(WORD_BITS-1){1'b1}});
  localparam logic [QUO_BITS-1:0] Q_NEG_LIM = QUO_BITS'(1) << (WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0] W_POS    = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] W_NEG    = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                        en;
  logic [2:0][WORD_BITS-1:0]   a_vec;
  logic [2:0][WORD_BITS-1:0]   b_vec;
  logic [NCELL:0]              vchain;
  pipe_t                       pchain [NCELL+1];
  pipe_t                       last;
  logic [3:0][WORD_BITS-1:0]   res_next;
  logic [1:0]                  status_next;
  logic [3:0][WORD_BITS-1:0]   out_res;
  logic [1:0]                  out_status;
  logic [3:0]                  out_func;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign a_vec[i] = s_tdata[4 + WORD_BITS*i +: WORD_BITS];
    assign b_vec[i] = s_tdata[4 + WORD_BITS*(i+3) +: WORD_BITS];
  end

  v3au_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .func      (s_tdata[3:0]),
    .a_vec     (a_vec),
    .b_vec     (b_vec),
    .s_val     (s_tdata[4 + WORD_BITS*6 +: WORD_BITS]),
    .out_valid (vchain[0]),
    .out_pipe  (pchain[0])
  );

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_sqrt
    v3au_sqrt_cell #(.BIT(WORD_BITS - 1 - k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vchain[k]),
      .in_pipe   (pchain[k]),
      .out_valid (vchain[k+1]),
      .out_pipe  (pchain[k+1])
    );
  end

  for (genvar m = 0; m < QUO_BITS; m++) begin : g_div
    v3au_div_cell #(.BIT(QUO_BITS - 1 - m)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vchain[WORD_BITS+m]),
      .in_pipe   (pchain[WORD_BITS+m]),
      .out_valid (vchain[WORD_BITS+m+1]),
      .out_pipe  (pchain[WORD_BITS+m+1])
    );
  end

  assign last = pchain[NCELL];

  always_comb begin
    logic sat;
    logic zero;
    logic [QUO_BITS-1:0] q;
    logic [QUO_BITS-1:0] q_neg;
    res_next = last.res;
    sat      = last.sat;
    zero     = 1'b0;
    case (last.func)
      F_MAG: begin
        if (last.root > W_POS) begin
          sat         = 1'b1;
          res_next[3] = W_POS;
        end else begin
          res_next[3] = last.root;
        end
      end
      F_NORM: begin
        if (last.root == '0) begin
          zero = 1'b1;
          for (int i = 0; i < 3; i++) begin
            res_next[i] = last.a_raw[i];
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            q     = last.quo[i];
            q_neg = -q;
            if (last.a_neg[i]) begin
              if (q > Q_NEG_LIM) begin
                sat         = 1'b1;
                res_next[i] = W_NEG;
              end else begin
                res_next[i] = q_neg[WORD_BITS-1:0];
              end
            end else if (q > Q_POS_LIM) begin
              sat         = 1'b1;
              res_next[i] = W_POS;
            end else begin
              res_next[i] = q[WORD_BITS-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (zero) begin
      status_next = ST_ZERO;
    end else if (sat) begin
      status_next = ST_SAT;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vchain[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res    <= res_next;
      out_status <= status_next;
      out_func   <= last.func;
    end
  end

  assign m_tdata = {{(OUT_BITS - 4*WORD_BITS - 2){1'b0}}, out_status, out_res};

  `V3AU_ASSERT_NEXT(a_stall_holds_row, m_tvalid && !m_tready, $stable(vchain), "cell row moved while output stalled")
  `V3AU_ASSERT(a_status_code, !m_tvalid || out_status == ST_OK || out_status == ST_SAT || out_status == ST_ZERO, "undefined status code")
  `V3AU_ASSERT(a_zero_only_norm, !m_tvalid || out_status != ST_ZERO || out_func == F_NORM, "zero-length status on an operation other than normalize")

endmodule

`default_nettype wire
